@@ sv/mbc3_pkg.sv @@
`default_nettype none

package mbc3_pkg;

	localparam int RAM_BYTES     = 32768;
	localparam int RAM_AW        = $clog2(RAM_BYTES);
	localparam int ROM_BANKS_MAX = 256;
	localparam int RAM_IDX_W     = 15;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_TICK  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CFG_ROM_BANK_MASK = 2'd0,
		CFG_WIDE_BANK     = 2'd1,
		CFG_RAM_SIZE      = 2'd2
	} cfg_index_t;

	// bus address regions, address bits 15:13
	localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
	localparam logic [2:0] REGION_ROM_BANK   = 3'd1;
	localparam logic [2:0] REGION_RAM_SELECT = 3'd2;
	localparam logic [2:0] REGION_LATCH      = 3'd3;
	localparam logic [2:0] REGION_EXT_RAM    = 3'd5;

	localparam logic [1:0] RAM_SIZE_NONE = 2'd0;
	localparam logic [1:0] RAM_SIZE_2K   = 2'd1;
	localparam logic [1:0] RAM_SIZE_8K   = 2'd2;
	localparam logic [1:0] RAM_SIZE_32K  = 2'd3;

	localparam logic [3:0] RTC_SEC    = 4'd8;
	localparam logic [3:0] RTC_MIN    = 4'd9;
	localparam logic [3:0] RTC_HOUR   = 4'd10;
	localparam logic [3:0] RTC_DAY_LO = 4'd11;
	localparam logic [3:0] RTC_FLAGS  = 4'd12;

	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
	localparam logic [7:0] FLAGS_WR_MASK  = 8'hC1;
	localparam int         FLAG_DAY_HI    = 0;
	localparam int         FLAG_HALT      = 6;
	localparam int         FLAG_CARRY     = 7;
	localparam logic [6:0] SEC_PER_MIN    = 7'd60;
	localparam logic [5:0] HOURS_PER_DAY  = 6'd24;

	localparam logic [7:0] BYTE_FF       = 8'hFF;
	localparam logic [7:0] ROM_BANK_LIMIT = 8'(ROM_BANKS_MAX - 1);

	typedef struct packed {
		logic       tick;
		logic       wr;
		logic       latch;
		logic [3:0] idx;
		logic [7:0] data;
	} rtc_cmd_t;

	function automatic logic [RAM_AW-1:0] ram_mask(input logic [1:0] sel);
		logic [RAM_AW-1:0] m;
		case (sel)
			RAM_SIZE_2K:  m = RAM_AW'(((2048 < RAM_BYTES) ? 2048 : RAM_BYTES) - 1);
			RAM_SIZE_8K:  m = RAM_AW'(((8192 < RAM_BYTES) ? 8192 : RAM_BYTES) - 1);
			RAM_SIZE_32K: m = RAM_AW'(((32768 < RAM_BYTES) ? 32768 : RAM_BYTES) - 1);
			default:      m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

@@ sv/mbc3_rtc.sv @@
`default_nettype none

module mbc3_rtc (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mbc3_pkg::rtc_cmd_t  cmd,
	output logic [7:0]               rd_byte
);

	logic [5:0] sec_q, min_q;
	logic [4:0] hour_q;
	logic [7:0] day_q, flags_q;
	logic [5:0] lat_sec_q, lat_min_q;
	logic [4:0] lat_hour_q;
	logic [7:0] lat_day_q, lat_flags_q;

	logic [6:0] s_sum, m_sum;
	logic [5:0] h_sum;
	logic [9:0] d_sum;
	logic       s_c, m_c, h_c;
	logic [5:0] s_nxt, m_nxt;
	logic [4:0] h_nxt;

	always_comb begin
		s_sum = {1'b0, sec_q} + 7'd1;
		s_c   = s_sum >= mbc3_pkg::SEC_PER_MIN;
		s_nxt = s_c ? 6'(s_sum - mbc3_pkg::SEC_PER_MIN) : s_sum[5:0];
		m_sum = {1'b0, min_q} + {6'd0, s_c};
		m_c   = m_sum >= mbc3_pkg::SEC_PER_MIN;
		m_nxt = m_c ? 6'(m_sum - mbc3_pkg::SEC_PER_MIN) : m_sum[5:0];
		h_sum = {1'b0, hour_q} + {5'd0, m_c};
		h_c   = h_sum >= mbc3_pkg::HOURS_PER_DAY;
		h_nxt = h_c ? 5'(h_sum - mbc3_pkg::HOURS_PER_DAY) : h_sum[4:0];
		d_sum = {1'b0, flags_q[mbc3_pkg::FLAG_DAY_HI], day_q} + {9'd0, h_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q       <= '0;
			min_q       <= '0;
			hour_q      <= '0;
			day_q       <= '0;
			flags_q     <= '0;
			lat_sec_q   <= '0;
			lat_min_q   <= '0;
			lat_hour_q  <= '0;
			lat_day_q   <= '0;
			lat_flags_q <= '0;
		end else begin
			if (cmd.tick && !flags_q[mbc3_pkg::FLAG_HALT]) begin
				sec_q   <= s_nxt;
				min_q   <= m_nxt;
				hour_q  <= h_nxt;
				day_q   <= d_sum[7:0];
				flags_q <= {flags_q[mbc3_pkg::FLAG_CARRY] | d_sum[9],
					flags_q[mbc3_pkg::FLAG_HALT], 5'd0, d_sum[8]};
			end
			if (cmd.wr) begin
				case (cmd.idx)
					mbc3_pkg::RTC_SEC:    sec_q   <= cmd.data[5:0];
					mbc3_pkg::RTC_MIN:    min_q   <= cmd.data[5:0];
					mbc3_pkg::RTC_HOUR:   hour_q  <= cmd.data[4:0];
					mbc3_pkg::RTC_DAY_LO: day_q   <= cmd.data;
					mbc3_pkg::RTC_FLAGS:  flags_q <= cmd.data & mbc3_pkg::FLAGS_WR_MASK;
					default: ;
				endcase
			end
			if (cmd.latch) begin
				lat_sec_q   <= sec_q;
				lat_min_q   <= min_q;
				lat_hour_q  <= hour_q;
				lat_day_q   <= day_q;
				lat_flags_q <= flags_q;
			end
		end
	end

	always_comb begin
		case (cmd.idx)
			mbc3_pkg::RTC_SEC:    rd_byte = {2'd0, lat_sec_q};
			mbc3_pkg::RTC_MIN:    rd_byte = {2'd0, lat_min_q};
			mbc3_pkg::RTC_HOUR:   rd_byte = {3'd0, lat_hour_q};
			mbc3_pkg::RTC_DAY_LO: rd_byte = lat_day_q;
			mbc3_pkg::RTC_FLAGS:  rd_byte = lat_flags_q;
			default:              rd_byte = mbc3_pkg::BYTE_FF;
		endcase
	end

endmodule

`default_nettype wire

@@ sv/mbc3_bank_controller_with_rtc_core.sv @@
// Cartridge bank controller with real-time clock.
// Input channel s_*: one bus read, bus write or one-second tick per item.
//   s_tuser carries the kind, s_tdata the bus address and the write byte.
// Output channel m_*: exactly one result item per input item, in order.
//   m_tuser is the ROM flag; m_tdata holds the read byte and ROM address.
// cfg_*: register writes; the user must see that they are taken only while no item is in flight.
// An accepted item passes the read stage, then the output register, to m_*.
// One item is taken every cycle unless the output stalls or the sweep runs;
// the cartridge RAM is a single-port synchronous memory read or written at
// most once per item, and its registered read data feeds the output stage.
// After reset the RAM is swept to zero, one byte a cycle, over all RAM_BYTES
// addresses (32768); s_tready stays low during the sweep. Bank, select, latch
// and clock registers take their reset values at once.
// When the receiver stalls, the output register holds its item and one more
// item may enter the read stage; s_tready then drops until m_tready returns.
`default_nettype none

module mbc3_bank_controller_with_rtc_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // bus_address[15:0], write_data[23:16]
	input  wire logic [1:0]  s_tuser,   // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // read_data[7:0], rom_address[29:8], zero
	output logic             m_tuser,   // rom_access
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	localparam int AW = mbc3_pkg::RAM_AW;

	logic [7:0] rom_mask_q;
	logic       wide_q;
	logic [1:0] ram_size_q;

	logic       ram_en_q;
	logic [7:0] rom_bank_q;
	logic [1:0] ram_bank_q;
	logic       clk_sel_q;
	logic [3:0] clk_idx_q;
	logic       armed_q;

	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	logic [7:0] ram [mbc3_pkg::RAM_BYTES];
	logic [7:0] ram_rdata_s1;

	logic        valid_s1, use_ram_s1, racc_s1;
	logic [7:0]  rd_s1;
	logic [21:0] raddr_s1;
	logic        valid_s2, racc_s2;
	logic [7:0]  rd_s2;
	logic [21:0] raddr_s2;

	logic [15:0] addr;
	logic [7:0]  wdata;
	logic [2:0]  region;
	logic        accept, adv_s1, s2_free;
	logic        is_rd, is_wr, is_tick;
	logic        ram_path, ext_ok;
	logic [AW-1:0] ram_idx, ram_wa;
	logic        ram_we, ram_re;
	logic [7:0]  ram_wd, rtc_byte;
	logic [7:0]  bank_w;
	logic        rd_acc;
	logic [7:0]  rd_val;
	logic [21:0] rd_addr;
	mbc3_pkg::rtc_cmd_t rtc_cmd;

	assign addr   = s_tdata[15:0];
	assign wdata  = s_tdata[23:16];
	assign region = addr[15:13];

	assign s2_free  = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && s2_free;
	assign s_tready = !clearing_q && (!valid_s1 || s2_free);
	assign accept   = s_tvalid && s_tready;

	assign is_rd   = accept && (s_tuser == mbc3_pkg::KIND_READ);
	assign is_wr   = accept && (s_tuser == mbc3_pkg::KIND_WRITE);
	assign is_tick = accept && (s_tuser == mbc3_pkg::KIND_TICK);

	assign ext_ok   = (region == mbc3_pkg::REGION_EXT_RAM) && ram_en_q;
	assign ram_path = ext_ok && !clk_sel_q && (ram_size_q != mbc3_pkg::RAM_SIZE_NONE);
	assign ram_idx  = AW'({ram_bank_q, addr[12:0]}) & mbc3_pkg::ram_mask(ram_size_q);

	assign ram_we = clearing_q || (is_wr && ram_path);
	assign ram_wa = clearing_q ? clr_addr_q : ram_idx;
	assign ram_wd = clearing_q ? 8'd0 : wdata;
	assign ram_re = is_rd && ram_path;

	always_ff @(posedge clk) begin
		if (ram_we) begin
			ram[ram_wa] <= ram_wd;
		end
		if (ram_re) begin
			ram_rdata_s1 <= ram[ram_idx];
		end
	end

	always_comb begin
		rtc_cmd.tick  = is_tick;
		rtc_cmd.wr    = is_wr && ext_ok && clk_sel_q;
		rtc_cmd.latch = is_wr && (region == mbc3_pkg::REGION_LATCH) && armed_q
			&& (wdata == 8'd1);
		rtc_cmd.idx   = clk_idx_q;
		rtc_cmd.data  = wdata;
	end

	mbc3_rtc u_rtc (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (rtc_cmd),
		.rd_byte (rtc_byte)
	);

	always_comb begin
		bank_w = (wide_q ? wdata : {1'b0, wdata[6:0]}) & rom_mask_q
			& mbc3_pkg::ROM_BANK_LIMIT;
	end

	always_comb begin
		rd_acc  = 1'b0;
		rd_addr = '0;
		rd_val  = mbc3_pkg::BYTE_FF;
		if (s_tuser == mbc3_pkg::KIND_READ) begin
			if (addr[15:14] == 2'd0) begin
				rd_acc  = 1'b1;
				rd_addr = {8'd0, addr[13:0]};
			end else if (addr[15:14] == 2'd1) begin
				rd_acc  = 1'b1;
				rd_addr = {rom_bank_q, addr[13:0]};
			end else if (ext_ok && clk_sel_q) begin
				rd_val = rtc_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_mask_q <= 8'd127;
			wide_q     <= 1'b0;
			ram_size_q <= mbc3_pkg::RAM_SIZE_32K;
			ram_en_q   <= 1'b0;
			rom_bank_q <= 8'd1;
			ram_bank_q <= '0;
			clk_sel_q  <= 1'b0;
			clk_idx_q  <= mbc3_pkg::RTC_SEC;
			armed_q    <= 1'b0;
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (&clr_addr_q) begin
					clearing_q <= 1'b0;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					mbc3_pkg::CFG_ROM_BANK_MASK: rom_mask_q <= cfg_data;
					mbc3_pkg::CFG_WIDE_BANK:     wide_q     <= cfg_data[0];
					mbc3_pkg::CFG_RAM_SIZE:      ram_size_q <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (is_wr) begin
				case (region)
					mbc3_pkg::REGION_RAM_ENABLE: begin
						ram_en_q <= (wdata[3:0] == mbc3_pkg::RAM_ENABLE_KEY);
					end
					mbc3_pkg::REGION_ROM_BANK: begin
						rom_bank_q <= (bank_w == 8'd0) ? 8'd1 : bank_w;
					end
					mbc3_pkg::REGION_RAM_SELECT: begin
						if (wdata <= 8'd3) begin
							ram_bank_q <= wdata[1:0];
							clk_sel_q  <= 1'b0;
						end else if (wdata inside {[8'd8:8'd12]}) begin
							clk_sel_q <= 1'b1;
							clk_idx_q <= wdata[3:0];
						end
					end
					mbc3_pkg::REGION_LATCH: begin
						armed_q <= (wdata == 8'd0) && !armed_q;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			use_ram_s1 <= ram_re;
			racc_s1    <= rd_acc;
			rd_s1      <= rd_val;
			raddr_s1   <= rd_addr;
		end
		if (adv_s1) begin
			racc_s2  <= racc_s1;
			raddr_s2 <= raddr_s1;
			rd_s2    <= use_ram_s1 ? ram_rdata_s1 : rd_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = racc_s2;
	assign m_tdata  = {2'b00, raddr_s2, rd_s2};

endmodule

`default_nettype wire

@@ bench/mbc3_bank_controller_with_rtc_core_checker.sv @@
`timescale 1ns / 100ps

module mbc3_bank_controller_with_rtc_core_checker
	import mbc3_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [23:0] s_tdata,   // bus_address[15:0], write_data[23:16]
	input  wire logic [1:0]  s_tuser,   // kind
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,   // read_data[7:0], rom_address[29:8], zero
	input  wire logic        m_tuser,   // rom_access
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	output int               errors,
	output int               outstanding
);

	typedef struct packed {
		logic [7:0]  read_data;
		logic        rom_access;
		logic [21:0] rom_address;
	} bus_result_t;

	bus_result_t bus_results_q[$];

	logic [7:0]  bank_mask;
	logic        wide_banks;
	logic [1:0]  ram_size;

	logic        ram_en;
	logic [7:0]  rom_page;
	logic [1:0]  ram_page;
	logic        rtc_sel;
	logic [3:0]  rtc_index;
	logic        latch_armed;
	logic [5:0]  live_sec;
	logic [5:0]  live_min;
	logic [4:0]  live_hrs;
	logic [7:0]  live_days;
	logic [7:0]  live_flags;
	logic [32:0] latched_clock;
	logic [7:0]  cart_ram [RAM_BYTES];

	function automatic logic [14:0] ram_slot(input logic [15:0] a);
		logic [14:0] span;
		case (ram_size)
			RAM_SIZE_2K:  span = 15'h07FF;
			RAM_SIZE_8K:  span = 15'h1FFF;
			default:      span = 15'h7FFF;
		endcase
		return {ram_page, a[12:0]} & span;
	endfunction

	function automatic logic [7:0] latched_byte();
		case (rtc_index)
			RTC_SEC:    return {2'd0, latched_clock[5:0]};
			RTC_MIN:    return {2'd0, latched_clock[11:6]};
			RTC_HOUR:   return {3'd0, latched_clock[16:12]};
			RTC_DAY_LO: return latched_clock[24:17];
			RTC_FLAGS:  return latched_clock[32:25];
			default:    return BYTE_FF;
		endcase
	endfunction

	task automatic advance_clock();
		int s, m, h, d;
		if (live_flags[FLAG_HALT])
			return;
		s = live_sec + 1;
		m = live_min + s / 60;
		h = live_hrs + m / 60;
		d = {live_flags[FLAG_DAY_HI], live_days} + h / 24;
		live_sec = 6'(s % 60);
		live_min = 6'(m % 60);
		live_hrs = 5'(h % 24);
		live_days = d[7:0];
		live_flags = {live_flags[7:6], 5'd0, d[8]};
		if (d > 511)
			live_flags[FLAG_CARRY] = 1'b1;
	endtask

	task automatic bus_write(input logic [15:0] a, input logic [7:0] v);
		logic [7:0] b;
		case (a[15:13])
			REGION_RAM_ENABLE: ram_en = (v[3:0] == RAM_ENABLE_KEY);
			REGION_ROM_BANK: begin
				b = wide_banks ? v : {1'b0, v[6:0]};
				b &= bank_mask & ROM_BANK_LIMIT;
				rom_page = (b == 8'd0) ? 8'd1 : b;
			end
			REGION_RAM_SELECT: begin
				if (v <= 8'd3) begin
					ram_page = v[1:0];
					rtc_sel = 1'b0;
				end else if (v >= RTC_SEC && v <= RTC_FLAGS) begin
					rtc_sel = 1'b1;
					rtc_index = v[3:0];
				end
			end
			REGION_LATCH: begin
				if (v == 8'd0 && !latch_armed) begin
					latch_armed = 1'b1;
				end else if (latch_armed && v == 8'd1) begin
					latched_clock = {live_flags, live_days, live_hrs, live_min, live_sec};
					latch_armed = 1'b0;
				end else begin
					latch_armed = 1'b0;
				end
			end
			REGION_EXT_RAM: begin
				if (ram_en && rtc_sel) begin
					case (rtc_index)
						RTC_SEC:    live_sec = v[5:0];
						RTC_MIN:    live_min = v[5:0];
						RTC_HOUR:   live_hrs = v[4:0];
						RTC_DAY_LO: live_days = v;
						RTC_FLAGS:  live_flags = v & FLAGS_WR_MASK;
						default: ;
					endcase
				end else if (ram_en && ram_size != RAM_SIZE_NONE) begin
					cart_ram[ram_slot(a)] = v;
				end
			end
			default: ;
		endcase
	endtask

	task automatic cartridge_access(input logic [1:0] k, input logic [15:0] a,
			input logic [7:0] v, output bus_result_t r);
		r = '{read_data: BYTE_FF, rom_access: 1'b0, rom_address: '0};
		case (k)
			KIND_READ: begin
				if (!a[15]) begin
					r.rom_access = 1'b1;
					r.rom_address = a[14] ? {rom_page, a[13:0]} : {8'd0, a[13:0]};
				end else if (a[15:13] == REGION_EXT_RAM && ram_en) begin
					if (rtc_sel)
						r.read_data = latched_byte();
					else if (ram_size != RAM_SIZE_NONE)
						r.read_data = cart_ram[ram_slot(a)];
				end
			end
			KIND_WRITE: bus_write(a, v);
			KIND_TICK:  advance_clock();
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		bus_result_t want, got;
		if (!arst_n) begin
			bank_mask = 8'd127;
			wide_banks = 1'b0;
			ram_size = RAM_SIZE_32K;
			ram_en = 1'b0;
			rom_page = 8'd1;
			ram_page = 2'd0;
			rtc_sel = 1'b0;
			rtc_index = RTC_SEC;
			latch_armed = 1'b0;
			live_sec = '0;
			live_min = '0;
			live_hrs = '0;
			live_days = '0;
			live_flags = '0;
			latched_clock = '0;
			foreach (cart_ram[i])
				cart_ram[i] = 8'd0;
			bus_results_q.delete();
			errors = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{read_data: m_tdata[7:0], rom_access: m_tuser,
					rom_address: m_tdata[29:8]};
				if (bus_results_q.size() == 0) begin
					$display("%0t: result with none expected: rd=%h rom=%b addr=%h",
						$time, got.read_data, got.rom_access, got.rom_address);
					errors++;
				end else begin
					want = bus_results_q.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch: expected rd=%h rom=%b addr=%h, actual rd=%h rom=%b addr=%h",
							$time, want.read_data, want.rom_access, want.rom_address,
							got.read_data, got.rom_access, got.rom_address);
						errors++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROM_BANK_MASK: bank_mask = cfg_data;
					CFG_WIDE_BANK:     wide_banks = cfg_data[0];
					CFG_RAM_SIZE:      ram_size = cfg_data[1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				cartridge_access(s_tuser, s_tdata[15:0], s_tdata[23:16], want);
				bus_results_q.push_back(want);
			end
		end
		outstanding = bus_results_q.size();
	end

endmodule

@@ bench/mbc3_bank_controller_with_rtc_core_tb.sv @@
`timescale 1ns / 100ps

module mbc3_bank_controller_with_rtc_core_tb;
	import mbc3_pkg::*;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int WATCHDOG_LIMIT = 100000;
	localparam int STALL_CYCLES = 300;
	localparam int SEGMENTS = 6;
	localparam int SEGMENT_ITEMS = 135;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // bus_address[15:0], write_data[23:16]
	logic [1:0]  s_tuser = KIND_READ;   // kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;   // read_data[7:0], rom_address[29:8], zero
	logic        m_tuser;   // rom_access
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_ROM_BANK_MASK;
	logic [7:0]  cfg_data = '0;

	int errors;
	int outstanding;
	int quiet_cycles = 0;
	int source_idle_pct = 26;
	int sink_idle_pct = 83;
	bit stall_request = 1'b0;

	logic [7:0] seg_mask [SEGMENTS] = '{8'd255, 8'd1, 8'd7, 8'd127, 8'd31, 8'd255};
	logic       seg_wide [SEGMENTS] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
	logic [1:0] seg_ram  [SEGMENTS] = '{RAM_SIZE_32K, RAM_SIZE_NONE, RAM_SIZE_2K,
		RAM_SIZE_8K, RAM_SIZE_32K, RAM_SIZE_2K};

	mbc3_bank_controller_with_rtc_core DUT (.*);

	mbc3_bank_controller_with_rtc_core_checker checker_i (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (stall_request) begin
				m_tready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
				stall_request = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic send_item(input logic [1:0] k, input logic [15:0] a, input logic [7:0] d);
		while ($urandom_range(99) < source_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= {d, a};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] mask, input logic wide, input logic [1:0] rsel);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_ROM_BANK_MASK;
		cfg_data <= mask;
		@(posedge clk);
		cfg_index <= CFG_WIDE_BANK;
		cfg_data <= {7'd0, wide};
		@(posedge clk);
		cfg_index <= CFG_RAM_SIZE;
		cfg_data <= {6'd0, rsel};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly well-formed register traffic so that RAM and the clock stay reachable
	task automatic random_item();
		int pick;
		logic [1:0] k;
		logic [15:0] a;
		logic [7:0] d;
		pick = $urandom_range(99);
		a = 16'($urandom);
		d = 8'($urandom);
		if (pick < 34) begin
			k = KIND_READ;
			case ($urandom_range(4))
				0: a[15:14] = 2'b00;
				1: a[15:14] = 2'b01;
				2, 3: a[15:13] = REGION_EXT_RAM;
				default: ;
			endcase
		end else if (pick < 82) begin
			k = KIND_WRITE;
			case ($urandom_range(9))
				0: begin
					a[15:13] = REGION_RAM_ENABLE;
					if ($urandom_range(3) != 0)
						d[3:0] = RAM_ENABLE_KEY;
				end
				1: a[15:13] = REGION_ROM_BANK;
				2: begin
					a[15:13] = REGION_RAM_SELECT;
					case ($urandom_range(2))
						0: d = {6'd0, d[1:0]};
						1: d = RTC_SEC + 8'($urandom_range(4));
						default: ;
					endcase
				end
				3: begin
					a[15:13] = REGION_LATCH;
					if ($urandom_range(3) != 0)
						d = {7'd0, d[0]};
				end
				4, 5, 6, 7: a[15:13] = REGION_EXT_RAM;
				default: ;
			endcase
		end else if (pick < 98) begin
			k = KIND_TICK;
		end else begin
			k = KIND_NONE;
		end
		send_item(k, a, d);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		send_item(KIND_READ, 16'h0000, 8'h00);
		send_item(KIND_READ, 16'h7FFF, 8'hFF);
		send_item(KIND_WRITE, 16'h2000, 8'h00);
		send_item(KIND_WRITE, 16'h3FFF, 8'hFF);
		send_item(KIND_READ, 16'h4000, 8'h00);
		send_item(KIND_READ, 16'hA000, 8'h00);
		send_item(KIND_WRITE, 16'h1FFF, 8'hFA);
		send_item(KIND_WRITE, 16'h5FFF, 8'h03);
		send_item(KIND_WRITE, 16'hBFFF, 8'h5A);
		send_item(KIND_READ, 16'hBFFF, 8'h00);
		send_item(KIND_WRITE, 16'h4000, 8'h07);
		send_item(KIND_WRITE, 16'h4000, 8'h0D);
		send_item(KIND_WRITE, 16'h4000, {4'd0, RTC_SEC});
		send_item(KIND_WRITE, 16'hA000, 8'd59);
		send_item(KIND_WRITE, 16'h4000, {4'd0, RTC_MIN});
		send_item(KIND_WRITE, 16'hA000, 8'd59);
		send_item(KIND_WRITE, 16'h4000, {4'd0, RTC_HOUR});
		send_item(KIND_WRITE, 16'hA000, 8'd23);
		send_item(KIND_WRITE, 16'h4000, {4'd0, RTC_DAY_LO});
		send_item(KIND_WRITE, 16'hA000, 8'hFF);
		send_item(KIND_WRITE, 16'h4000, {4'd0, RTC_FLAGS});
		send_item(KIND_WRITE, 16'hA000, 8'h01);
		send_item(KIND_TICK, 16'hFFFF, 8'hFF);
		send_item(KIND_WRITE, 16'h6000, 8'h00);
		send_item(KIND_WRITE, 16'h7FFF, 8'h01);
		send_item(KIND_READ, 16'hA000, 8'h00);
		send_item(KIND_WRITE, 16'hA000, 8'hFF);
		send_item(KIND_TICK, 16'h0000, 8'h00);
		send_item(KIND_WRITE, 16'h6000, 8'h00);
		send_item(KIND_WRITE, 16'h6000, 8'h00);
		send_item(KIND_WRITE, 16'h6000, 8'h01);
		send_item(KIND_WRITE, 16'h9FFF, 8'h0A);
		send_item(KIND_READ, 16'hC000, 8'h00);
		send_item(KIND_NONE, 16'h2000, 8'h02);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			set_config(seg_mask[seg], seg_wide[seg], seg_ram[seg]);
			source_idle_pct = (seg < 2) ? 26 : (seg < 4) ? 83 : 0;
			sink_idle_pct = (seg < 2) ? 83 : (seg < 4) ? 26 : 0;
			if (seg == 4)
				stall_request = 1'b1;
			repeat (SEGMENT_ITEMS) random_item();
		end

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
